>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the execute unit. Each use expects clk and rst_n
// in scope; checks are off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sbeu_pkg.sv
// ----------------------------------------------------------------------------
// sbeu_pkg
// Shared widths, opcodes, error codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package sbeu_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 6;
    localparam int LIDX_W  = 8;
    localparam int BADDR_W = 12;
    localparam int CNT_W   = 8;
    localparam int RADDR_W = 24;
    localparam int ERR_W   = 3;

    localparam int VALUE_DEPTH_DEF   = 2048;
    localparam int FRAME_DEPTH_DEF   = 128;
    localparam int BYTE_MEM_SIZE_DEF = 4096;

    localparam logic [OP_W-1:0] OP_RET       = 6'd0;
    localparam logic [OP_W-1:0] OP_RET32     = 6'd1;
    localparam logic [OP_W-1:0] OP_PUSH      = 6'd2;
    localparam logic [OP_W-1:0] OP_CALL      = 6'd3;
    localparam logic [OP_W-1:0] OP_PUSHLOCAL = 6'd4;
    localparam logic [OP_W-1:0] OP_ADD       = 6'd5;
    localparam logic [OP_W-1:0] OP_SUB       = 6'd6;
    localparam logic [OP_W-1:0] OP_MUL       = 6'd7;
    localparam logic [OP_W-1:0] OP_DIV       = 6'd8;
    localparam logic [OP_W-1:0] OP_SETLOCAL  = 6'd9;
    localparam logic [OP_W-1:0] OP_LPOSTINC  = 6'd10;
    localparam logic [OP_W-1:0] OP_LPREINC   = 6'd11;
    localparam logic [OP_W-1:0] OP_LPOSTDEC  = 6'd12;
    localparam logic [OP_W-1:0] OP_LPREDEC   = 6'd13;
    localparam logic [OP_W-1:0] OP_MEMSET8   = 6'd14;
    localparam logic [OP_W-1:0] OP_MEMPUSH8  = 6'd15;
    localparam logic [OP_W-1:0] OP_PUSHADDR  = 6'd16;
    localparam logic [OP_W-1:0] OP_IF        = 6'd17;
    localparam logic [OP_W-1:0] OP_JUMP      = 6'd18;
    localparam logic [OP_W-1:0] OP_NOT       = 6'd19;
    localparam logic [OP_W-1:0] OP_LT        = 6'd20;
    localparam logic [OP_W-1:0] OP_GT        = 6'd21;
    localparam logic [OP_W-1:0] OP_EQ        = 6'd22;
    localparam logic [OP_W-1:0] OP_LE        = 6'd23;
    localparam logic [OP_W-1:0] OP_GE        = 6'd24;
    localparam logic [OP_W-1:0] OP_NE        = 6'd25;
    localparam logic [OP_W-1:0] OP_MPOSTINC  = 6'd26;
    localparam logic [OP_W-1:0] OP_MPREINC   = 6'd27;
    localparam logic [OP_W-1:0] OP_POP       = 6'd28;
    localparam logic [OP_W-1:0] OP_MPOSTDEC  = 6'd29;
    localparam logic [OP_W-1:0] OP_MPREDEC   = 6'd30;
    localparam logic [OP_W-1:0] OP_LAND      = 6'd31;
    localparam logic [OP_W-1:0] OP_LOR       = 6'd32;
    localparam logic [OP_W-1:0] OP_START     = 6'd33;

    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_STACK  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DIV0   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FRAME  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OPCODE = 3'd4;

    typedef struct packed {
        logic load;
        logic rd_sec;
        logic check;
        logic div_start;
        logic exec;
        logic wr1;
        logic wr2;
        logic top_cap;
        logic out_load;
    } sbeu_cmd_t;

    typedef struct packed {
        logic err;
        logic is_div;
        logic two_wr;
        logic div_done;
        logic out_free;
        logic clr_busy;
    } sbeu_status_t;

endpackage

>>> sv/sbeu_in_if.sv
// ----------------------------------------------------------------------------
// sbeu_in_if
// Instruction request channel: valid/ready with the decoded fields.
// ----------------------------------------------------------------------------
interface sbeu_in_if;
    logic               valid;
    logic               ready;
    logic [5:0]         op;
    logic signed [31:0] immediate;
    logic [7:0]         local_index;
    logic [11:0]        byte_address;
    logic [7:0]         callee_arg_count;
    logic [7:0]         callee_local_count;
    logic [23:0]        return_address;

    modport source (
        output valid, op, immediate, local_index, byte_address,
               callee_arg_count, callee_local_count, return_address,
        input  ready
    );
    modport sink (
        input  valid, op, immediate, local_index, byte_address,
               callee_arg_count, callee_local_count, return_address,
        output ready
    );
endinterface

>>> sv/sbeu_out_if.sv
// ----------------------------------------------------------------------------
// sbeu_out_if
// Result request channel: valid/ready with the step outcome.
// ----------------------------------------------------------------------------
interface sbeu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic               branch_taken;
    logic               resume_valid;
    logic [23:0]        resume_address;
    logic               finished;
    logic [2:0]         error;

    modport source (
        output valid, top_value, branch_taken, resume_valid, resume_address,
               finished, error,
        input  ready
    );
    modport sink (
        input  valid, top_value, branch_taken, resume_valid, resume_address,
               finished, error,
        output ready
    );
endinterface

>>> sv/sbeu_ram.sv
// ----------------------------------------------------------------------------
// sbeu_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/sbeu_div.sv
// ----------------------------------------------------------------------------
// sbeu_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sbeu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sbeu_pkg::DATA_W-1:0] dividend,
    input  logic [sbeu_pkg::DATA_W-1:0] divisor,
    output logic [sbeu_pkg::DATA_W-1:0] quotient,
    output logic                        done
);
    import sbeu_pkg::*;

    localparam int CW = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;

    assign ua     = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
    assign ub     = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;
    assign rem_sh = {rem_reg[DATA_W-1:0], q_reg[DATA_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= ua;
            dvs_reg <= ub;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step: keep the trial remainder when it is not negative
            if (!trial[DATA_W])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = neg_reg ? (~q_reg + DATA_W'(1)) : q_reg;
    assign done     = done_reg;
endmodule

>>> sv/sbeu_datapath.sv
// ----------------------------------------------------------------------------
// sbeu_datapath
// Stack, frame and byte memories, machine pointers, ALU and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbeu_datapath #(
    parameter int VALUE_DEPTH   = sbeu_pkg::VALUE_DEPTH_DEF,
    parameter int FRAME_DEPTH   = sbeu_pkg::FRAME_DEPTH_DEF,
    parameter int BYTE_MEM_SIZE = sbeu_pkg::BYTE_MEM_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbeu_pkg::sbeu_cmd_t           cmd,
    output sbeu_pkg::sbeu_status_t        status,
    input  logic [sbeu_pkg::OP_W-1:0]     op,
    input  logic signed [sbeu_pkg::DATA_W-1:0] immediate,
    input  logic [sbeu_pkg::LIDX_W-1:0]   local_index,
    input  logic [sbeu_pkg::BADDR_W-1:0]  byte_address,
    input  logic [sbeu_pkg::CNT_W-1:0]    callee_arg_count,
    input  logic [sbeu_pkg::CNT_W-1:0]    callee_local_count,
    input  logic [sbeu_pkg::RADDR_W-1:0]  return_address,
    output logic signed [sbeu_pkg::DATA_W-1:0] top_value,
    output logic                          branch_taken,
    output logic                          resume_valid,
    output logic [sbeu_pkg::RADDR_W-1:0]  resume_address,
    output logic                          finished,
    output logic [sbeu_pkg::ERR_W-1:0]    error,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import sbeu_pkg::*;

    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int SPW = $clog2(VALUE_DEPTH + 1);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int BAW = $clog2(BYTE_MEM_SIZE);
    localparam int EW  = SPW + CNT_W + 1;
    localparam int FRW = 2 * SPW + RADDR_W;

    localparam logic [EW-1:0]  VD_E = EW'(VALUE_DEPTH);
    localparam logic [SPW-1:0] VD_S = SPW'(VALUE_DEPTH);
    localparam logic [FCW-1:0] FD_C = FCW'(FRAME_DEPTH);
    localparam logic [BAW-1:0] BM_LAST = BAW'(BYTE_MEM_SIZE - 1);

    // latched instruction
    logic [OP_W-1:0]    op_reg;
    logic [DATA_W-1:0]  imm_reg;
    logic [LIDX_W-1:0]  lidx_reg;
    logic [BAW-1:0]     baddr_reg;
    logic [CNT_W-1:0]   argc_reg;
    logic [CNT_W-1:0]   lcnt_reg;
    logic [RADDR_W-1:0] raddr_reg;

    // machine state
    logic [SPW-1:0] sp_reg, sp_next;
    logic [SPW-1:0] fb_reg, fb_next;
    logic [FCW-1:0] fc_reg, fc_next;

    // operands and results
    logic [DATA_W-1:0] top_reg, sec_reg, fin_top_reg, res_reg, pv_reg;
    logic [7:0]        byte_reg, bnew_reg;
    logic [FRW-1:0]    frm_reg;
    logic [ERR_W-1:0]  err_reg;
    logic              br_reg, rv_reg, fin_reg, has_top_reg;
    logic [RADDR_W-1:0] ra_reg;

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic              out_br_reg, out_rv_reg, out_fin_reg;
    logic [RADDR_W-1:0] out_ra_reg;
    logic [ERR_W-1:0]  out_err_reg;

    // byte memory clearing pass
    logic           clr_busy_reg;
    logic [BAW-1:0] clr_cnt_reg;

    // memory ports
    logic              vs_we;
    logic [VAW-1:0]    vs_waddr, vs_raddr;
    logic [DATA_W-1:0] vs_wdata, vs_rdata;
    logic              bm_we, bm_we_op;
    logic [BAW-1:0]    bm_waddr;
    logic [7:0]        bm_wdata, bm_rdata;
    logic              fr_we;
    logic [FAW-1:0]    fr_waddr, fr_raddr;
    logic [FRW-1:0]    fr_wdata, fr_rdata;

    logic [BAW+BADDR_W-1:0] baddr_wide;
    logic [SPW-1:0]    sp_m1, sp_m2, call_fb, frm_pos, frm_fb;
    logic [RADDR_W-1:0] frm_addr;
    logic [FCW-1:0]    fc_m1;
    logic [EW-1:0]     slot_e, argl_e, spl_e;
    logic              sp_zero, sp_full, sp_lt2, slot_bad, fc_zero, is_local;
    logic [ERR_W-1:0]  err_comb;
    logic [DATA_W-1:0] res_comb, pv_comb, div_q, prod;
    logic [7:0]        bnew_comb;
    logic              br_comb, rv_comb, fin_comb, has_top_comb;
    logic              div_done;
    logic              lt_ab, lt_ba;

    assign baddr_wide = {{BAW{1'b0}}, byte_address};
    assign sp_m1      = sp_reg - SPW'(1);
    assign sp_m2      = sp_reg - SPW'(2);
    assign fc_m1      = fc_reg - FCW'(1);
    assign call_fb    = sp_reg - SPW'(argc_reg);
    assign frm_addr   = frm_reg[RADDR_W-1:0];
    assign frm_pos    = frm_reg[RADDR_W +: SPW];
    assign frm_fb     = frm_reg[RADDR_W + SPW +: SPW];
    assign slot_e     = EW'(fb_reg) + EW'(lidx_reg);
    assign argl_e     = EW'(argc_reg) + EW'(lcnt_reg);
    assign spl_e      = EW'(sp_reg) + EW'(lcnt_reg);
    assign sp_zero    = (sp_reg == '0);
    assign sp_full    = (sp_reg >= VD_S);
    assign sp_lt2     = (sp_reg < SPW'(2));
    assign slot_bad   = (slot_e >= VD_E);
    assign fc_zero    = (fc_reg == '0);
    assign is_local   = (op_reg == OP_PUSHLOCAL) || (op_reg == OP_SETLOCAL) ||
                        (op_reg == OP_LPOSTINC) || (op_reg == OP_LPREINC) ||
                        (op_reg == OP_LPOSTDEC) || (op_reg == OP_LPREDEC);

    // ---- memories ----
    sbeu_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_DEPTH)) u_value_ram (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
        .raddr(vs_raddr), .rdata(vs_rdata)
    );

    sbeu_ram #(.WIDTH(FRW), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fr_rdata)
    );

    sbeu_ram #(.WIDTH(8), .DEPTH(BYTE_MEM_SIZE)) u_byte_ram (
        .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
        .raddr(baddr_reg), .rdata(bm_rdata)
    );

    sbeu_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(sec_reg), .divisor(top_reg), .quotient(div_q), .done(div_done)
    );

    // second operand: a local slot or the entry under the top
    always_comb
    begin
        vs_raddr = sp_m1[VAW-1:0];
        if (cmd.rd_sec)
        begin
            vs_raddr = is_local ? slot_e[VAW-1:0] : sp_m2[VAW-1:0];
        end
    end

    assign fr_raddr = fc_m1[FAW-1:0];

    // ---- error check on the state before the step ----
    always_comb
    begin
        err_comb = ERR_NONE;
        unique case (op_reg) inside
            OP_RET, OP_JUMP:
                err_comb = ERR_NONE;
            OP_RET32:
                if (sp_zero || (!fc_zero && frm_pos >= VD_S))
                    err_comb = ERR_STACK;
            OP_PUSH, OP_PUSHADDR, OP_MEMPUSH8, OP_MPOSTINC, OP_MPREINC,
            OP_MPOSTDEC, OP_MPREDEC:
                if (sp_full)
                    err_comb = ERR_STACK;
            OP_CALL:
                if (fc_reg >= FD_C)
                    err_comb = ERR_FRAME;
                else if (sp_reg < SPW'(argc_reg) || EW'(argc_reg) > EW'(sp_reg) ||
                         spl_e > VD_E)
                    err_comb = ERR_STACK;
            OP_PUSHLOCAL, OP_LPOSTINC, OP_LPREINC, OP_LPOSTDEC, OP_LPREDEC:
                if (slot_bad || sp_full)
                    err_comb = ERR_STACK;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE,
            OP_NE, OP_LAND, OP_LOR:
                if (sp_lt2)
                    err_comb = ERR_STACK;
                else if (op_reg == OP_DIV && top_reg == '0)
                    err_comb = ERR_DIV0;
            OP_SETLOCAL:
                if (sp_zero || slot_bad)
                    err_comb = ERR_STACK;
            OP_MEMSET8, OP_IF, OP_NOT, OP_POP:
                if (sp_zero)
                    err_comb = ERR_STACK;
            OP_START:
                if (argl_e > VD_E)
                    err_comb = ERR_STACK;
            default:
                err_comb = ERR_OPCODE;
        endcase
    end

    // ---- ALU ----
    assign prod  = sec_reg * top_reg;
    assign lt_ab = $signed(sec_reg) < $signed(top_reg);
    assign lt_ba = $signed(top_reg) < $signed(sec_reg);

    always_comb
    begin
        res_comb  = '0;
        pv_comb   = sec_reg;
        bnew_comb = top_reg[7:0];
        case (op_reg)
            OP_ADD:       res_comb = sec_reg + top_reg;
            OP_SUB:       res_comb = sec_reg - top_reg;
            OP_MUL:       res_comb = prod;
            OP_DIV:       res_comb = div_q;
            OP_LT:        res_comb = DATA_W'(lt_ab);
            OP_GT:        res_comb = DATA_W'(lt_ba);
            OP_EQ:        res_comb = DATA_W'(sec_reg == top_reg);
            OP_LE:        res_comb = DATA_W'(!lt_ba);
            OP_GE:        res_comb = DATA_W'(!lt_ab);
            OP_NE:        res_comb = DATA_W'(sec_reg != top_reg);
            OP_LAND:      res_comb = DATA_W'(sec_reg != '0 && top_reg != '0);
            OP_LOR:       res_comb = DATA_W'(sec_reg != '0 || top_reg != '0);
            OP_NOT:       res_comb = DATA_W'(top_reg == '0);
            OP_RET32:     res_comb = top_reg;
            OP_SETLOCAL:  res_comb = top_reg;
            OP_PUSH:      res_comb = imm_reg;
            OP_PUSHADDR:  res_comb = DATA_W'(baddr_reg);
            OP_PUSHLOCAL: res_comb = sec_reg;
            OP_LPOSTINC:
            begin
                res_comb = sec_reg + DATA_W'(1);
                pv_comb  = sec_reg;
            end
            OP_LPREINC:
            begin
                res_comb = sec_reg + DATA_W'(1);
                pv_comb  = sec_reg + DATA_W'(1);
            end
            OP_LPOSTDEC:
            begin
                res_comb = sec_reg - DATA_W'(1);
                pv_comb  = sec_reg;
            end
            OP_LPREDEC:
            begin
                res_comb = sec_reg - DATA_W'(1);
                pv_comb  = sec_reg - DATA_W'(1);
            end
            OP_MEMPUSH8:  res_comb = DATA_W'(byte_reg);
            OP_MPOSTINC:
            begin
                res_comb  = DATA_W'(byte_reg);
                bnew_comb = byte_reg + 8'd1;
            end
            OP_MPREINC:
            begin
                bnew_comb = byte_reg + 8'd1;
                res_comb  = DATA_W'(bnew_comb);
            end
            OP_MPOSTDEC:
            begin
                res_comb  = DATA_W'(byte_reg);
                bnew_comb = byte_reg - 8'd1;
            end
            OP_MPREDEC:
            begin
                bnew_comb = byte_reg - 8'd1;
                res_comb  = DATA_W'(bnew_comb);
            end
            default:      res_comb = '0;
        endcase
    end

    // ---- write-back and pointer update ----
    always_comb
    begin
        vs_we        = 1'b0;
        vs_waddr     = sp_reg[VAW-1:0];
        vs_wdata     = res_reg;
        bm_we_op     = 1'b0;
        fr_we        = 1'b0;
        fr_waddr     = fc_reg[FAW-1:0];
        fr_wdata     = {fb_reg, call_fb, raddr_reg};
        sp_next      = sp_reg;
        fb_next      = fb_reg;
        fc_next      = fc_reg;
        br_comb      = 1'b0;
        rv_comb      = 1'b0;
        fin_comb     = 1'b0;
        has_top_comb = 1'b0;
        if (cmd.wr1)
        begin
            case (op_reg)
                OP_RET:
                    if (fc_zero)
                        fin_comb = 1'b1;
                    else
                    begin
                        fc_next = fc_m1;
                        sp_next = frm_pos;
                        fb_next = frm_fb;
                        rv_comb = 1'b1;
                    end
                OP_RET32:
                    if (fc_zero)
                    begin
                        fin_comb     = 1'b1;
                        has_top_comb = 1'b1;
                        sp_next      = sp_m1;
                        vs_we        = 1'b1;
                        vs_waddr     = '0;
                    end
                    else
                    begin
                        fc_next  = fc_m1;
                        sp_next  = frm_pos + SPW'(1);
                        fb_next  = frm_fb;
                        rv_comb  = 1'b1;
                        vs_we    = 1'b1;
                        vs_waddr = frm_pos[VAW-1:0];
                    end
                OP_PUSH, OP_PUSHADDR, OP_PUSHLOCAL, OP_MEMPUSH8:
                begin
                    vs_we   = 1'b1;
                    sp_next = sp_reg + SPW'(1);
                end
                OP_MPOSTINC, OP_MPREINC, OP_MPOSTDEC, OP_MPREDEC:
                begin
                    vs_we    = 1'b1;
                    bm_we_op = 1'b1;
                    sp_next  = sp_reg + SPW'(1);
                end
                OP_CALL:
                begin
                    fr_we   = 1'b1;
                    fb_next = call_fb;
                    sp_next = sp_reg + SPW'(lcnt_reg);
                    fc_next = fc_reg + FCW'(1);
                end
                OP_LPOSTINC, OP_LPREINC, OP_LPOSTDEC, OP_LPREDEC:
                begin
                    vs_we    = 1'b1;
                    vs_waddr = slot_e[VAW-1:0];
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_LE,
                OP_GE, OP_NE, OP_LAND, OP_LOR:
                begin
                    vs_we    = 1'b1;
                    vs_waddr = sp_m2[VAW-1:0];
                    sp_next  = sp_m1;
                end
                OP_SETLOCAL:
                begin
                    vs_we    = 1'b1;
                    vs_waddr = slot_e[VAW-1:0];
                    sp_next  = sp_m1;
                end
                OP_MEMSET8:
                begin
                    bm_we_op = 1'b1;
                    sp_next  = sp_m1;
                end
                OP_IF:
                begin
                    sp_next = sp_m1;
                    br_comb = (top_reg == '0);
                end
                OP_JUMP:
                    br_comb = 1'b1;
                OP_NOT:
                begin
                    vs_we    = 1'b1;
                    vs_waddr = sp_m1[VAW-1:0];
                end
                OP_POP:
                    sp_next = sp_m1;
                OP_START:
                begin
                    sp_next = SPW'(argl_e);
                    fb_next = '0;
                    fc_next = '0;
                end
                default:
                    sp_next = sp_reg;
            endcase
        end
        else if (cmd.wr2)
        begin
            // push the local's old or new value
            vs_we    = 1'b1;
            vs_wdata = pv_reg;
            sp_next  = sp_reg + SPW'(1);
        end
    end

    // clearing pass owns the byte memory write port
    assign bm_we    = clr_busy_reg | bm_we_op;
    assign bm_waddr = clr_busy_reg ? clr_cnt_reg : baddr_reg;
    assign bm_wdata = clr_busy_reg ? 8'd0 : bnew_reg;

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            fb_reg        <= '0;
            fc_reg        <= '0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg <= sp_next;
            fb_reg <= fb_next;
            fc_reg <= fc_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + BAW'(1);
                if (clr_cnt_reg == BM_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            imm_reg     <= immediate;
            lidx_reg    <= local_index;
            baddr_reg   <= baddr_wide[BAW-1:0];
            argc_reg    <= callee_arg_count;
            lcnt_reg    <= callee_local_count;
            raddr_reg   <= return_address;
            br_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            ra_reg      <= '0;
            fin_reg     <= 1'b0;
            has_top_reg <= 1'b0;
        end
        if (cmd.rd_sec)
        begin
            top_reg  <= vs_rdata;
            frm_reg  <= fr_rdata;
            byte_reg <= bm_rdata;
        end
        if (cmd.check)
        begin
            sec_reg <= vs_rdata;
            err_reg <= err_comb;
        end
        if (cmd.exec)
        begin
            res_reg  <= res_comb;
            pv_reg   <= pv_comb;
            bnew_reg <= bnew_comb;
        end
        if (cmd.wr1)
        begin
            br_reg      <= br_comb;
            rv_reg      <= rv_comb;
            ra_reg      <= rv_comb ? frm_addr : '0;
            fin_reg     <= fin_comb;
            has_top_reg <= has_top_comb;
        end
        if (cmd.top_cap)
        begin
            fin_top_reg <= vs_rdata;
        end
        if (cmd.out_load)
        begin
            out_top_reg <= has_top_reg ? res_reg : (sp_zero ? '0 : fin_top_reg);
            out_br_reg  <= br_reg;
            out_rv_reg  <= rv_reg;
            out_ra_reg  <= ra_reg;
            out_fin_reg <= fin_reg;
            out_err_reg <= err_reg;
        end
    end

    assign status.err      = (err_comb != ERR_NONE);
    assign status.is_div   = (op_reg == OP_DIV);
    assign status.two_wr   = (op_reg == OP_LPOSTINC) || (op_reg == OP_LPREINC) ||
                             (op_reg == OP_LPOSTDEC) || (op_reg == OP_LPREDEC);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.clr_busy = clr_busy_reg;

    assign top_value      = out_top_reg;
    assign branch_taken   = out_br_reg;
    assign resume_valid   = out_rv_reg;
    assign resume_address = out_ra_reg;
    assign finished       = out_fin_reg;
    assign error          = out_err_reg;
    assign out_valid      = out_valid_reg;

    `SBEU_ASSERT_NOW(a_sp_range, 1'b1, sp_reg <= VD_S, "stack pointer beyond value depth")
    `SBEU_ASSERT_NOW(a_fc_range, 1'b1, fc_reg <= FD_C, "frame count beyond frame depth")
    `SBEU_ASSERT_NOW(a_no_load_clr, clr_busy_reg, !cmd.load, "request taken during clear")
    `SBEU_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_reg || out_ready, "result overrun")
    `SBEU_ASSERT_NEXT(a_err_keeps, cmd.check && err_comb != ERR_NONE, $stable(sp_reg) && $stable(fc_reg) && $stable(fb_reg), "faulting step changed state")
endmodule

>>> sv/sbeu_ctrl.sv
// ----------------------------------------------------------------------------
// sbeu_ctrl
// Step sequencer: read operands, check, divide if needed, execute, write back
// (both skipped when the check faults), read new top, load the result.
module sbeu_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    output logic                   ready,
    input  sbeu_pkg::sbeu_status_t status,
    output sbeu_pkg::sbeu_cmd_t    cmd
);
    import sbeu_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_TOP   = 4'd1;
    localparam logic [3:0] S_RD_SEC   = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_DIV_GO   = 4'd4;
    localparam logic [3:0] S_DIV_WAIT = 4'd5;
    localparam logic [3:0] S_EXEC     = 4'd6;
    localparam logic [3:0] S_WR1      = 4'd7;
    localparam logic [3:0] S_WR2      = 4'd8;
    localparam logic [3:0] S_TOP_RD   = 4'd9;
    localparam logic [3:0] S_TOP_CAP  = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign ready  = (state_reg == S_IDLE) && !status.clr_busy;
    assign accept = valid && ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD_TOP;
                end
            S_RD_TOP:
                state_next = S_RD_SEC;
            S_RD_SEC:
            begin
                cmd.rd_sec = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.err)
                    state_next = S_TOP_RD;
                else if (status.is_div)
                    state_next = S_DIV_GO;
                else
                    state_next = S_EXEC;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
                if (status.div_done)
                    state_next = S_EXEC;
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr1    = 1'b1;
                state_next = status.two_wr ? S_WR2 : S_TOP_RD;
            end
            S_WR2:
            begin
                cmd.wr2    = 1'b1;
                state_next = S_TOP_RD;
            end
            S_TOP_RD:
                state_next = S_TOP_CAP;
            S_TOP_CAP:
            begin
                cmd.top_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> sv/stack_bytecode_execute_unit_core.sv
// Step: the request is latched, top and second operand are read and checked; a
//   divide runs the divider (one quotient bit per cycle); unless the check faults
//   the step executes and writes back; the new top is read. Top, second operand
//   and new top share the single value stack read port; one request at a time.
// Reset: pointers and frame count clear at once; the byte memory is then zeroed
//   one entry per cycle, with ready held low meanwhile.
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_core
// Execute stage of a 32-bit stack machine: value stack with frame locals,
// byte memory and call-frame stack, one decoded instruction per request.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit_core #(
    parameter int VALUE_DEPTH   = sbeu_pkg::VALUE_DEPTH_DEF,
    parameter int FRAME_DEPTH   = sbeu_pkg::FRAME_DEPTH_DEF,
    parameter int BYTE_MEM_SIZE = sbeu_pkg::BYTE_MEM_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sbeu_in_if.sink    in_ch,
    sbeu_out_if.source out_ch
);
    import sbeu_pkg::*;

    // Command and status link between sequencer and datapath.
    sbeu_cmd_t    cmd;
    sbeu_status_t status;

    // The sequencer owns the input handshake; it takes a request only when
    // idle and when the byte memory clear has finished.
    sbeu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (in_ch.valid),
        .ready  (in_ch.ready),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds all storage and the output register, which holds a
    // finished result until the sink takes it.
    sbeu_datapath #(
        .VALUE_DEPTH   (VALUE_DEPTH),
        .FRAME_DEPTH   (FRAME_DEPTH),
        .BYTE_MEM_SIZE (BYTE_MEM_SIZE)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .op                 (in_ch.op),
        .immediate          (in_ch.immediate),
        .local_index        (in_ch.local_index),
        .byte_address       (in_ch.byte_address),
        .callee_arg_count   (in_ch.callee_arg_count),
        .callee_local_count (in_ch.callee_local_count),
        .return_address     (in_ch.return_address),
        .top_value          (out_ch.top_value),
        .branch_taken       (out_ch.branch_taken),
        .resume_valid       (out_ch.resume_valid),
        .resume_address     (out_ch.resume_address),
        .finished           (out_ch.finished),
        .error              (out_ch.error),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready)
    );
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack machine execute unit. Instruction
// requests are driven through the input channel and results are compared
// field by field against a behavioral predictor of the value stack, byte
// memory and frame stack, or against the outcome typed in the table.
// ----------------------------------------------------------------------------
module testbench;
    import sbeu_pkg::*;

    localparam int VDEPTH     = VALUE_DEPTH_DEF;
    localparam int FDEPTH     = FRAME_DEPTH_DEF;
    localparam int MSIZE      = BYTE_MEM_SIZE_DEF;
    localparam int IDLE_LIMIT = 12000;  // covers the byte memory clear after reset
    localparam int DRAIN      = 60;     // longer than the divide latency
    localparam int LONG_HOLD  = 300;

    localparam logic [OP_W-1:0] OP_BAD = 6'd63;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [31:0]        immediate;
        logic [LIDX_W-1:0]  local_index;
        logic [BADDR_W-1:0] byte_address;
        logic [CNT_W-1:0]   callee_arg_count;
        logic [CNT_W-1:0]   callee_local_count;
        logic [RADDR_W-1:0] return_address;
    } instr_t;

    typedef struct {
        logic [31:0]        top_value;
        logic               branch_taken;
        logic               resume_valid;
        logic [RADDR_W-1:0] resume_address;
        logic               finished;
        logic [ERR_W-1:0]   error;
    } outcome_t;

    typedef struct {
        instr_t   ins;
        bit       typed;     // expected outcome written in the table
        outcome_t fixed;
    } row_t;

    logic clk;
    logic rst_n;

    sbeu_in_if  in_ch ();
    sbeu_out_if out_ch ();

    stack_bytecode_execute_unit_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Machine state as the predictor sees it.
    logic [31:0]        vstack [VDEPTH];
    logic [7:0]         bmem [MSIZE];
    int                 sp, fb, fc;
    int                 frame_pos [FDEPTH];
    int                 frame_fb [FDEPTH];
    logic [RADDR_W-1:0] frame_ret [FDEPTH];

    row_t     program_q[$];
    outcome_t pending_q[$];
    int       n_accepted, n_results, n_errors, idle_cycles, n_fail_err;
    bit       stim_done;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Predictor: execute one instruction against the local state.
    // ------------------------------------------------------------------------
    function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic outcome_t execute(instr_t it);
        outcome_t    r;
        logic [31:0] a, b, v;
        logic [7:0]  m;
        int          slot, f;
        bit          has_top;
        r = '{default: '0};
        has_top = 0;
        slot = fb + it.local_index;
        case (it.op)
            OP_RET, OP_RET32:
            begin
                if (it.op == OP_RET32 && sp == 0)
                    r.error = ERR_STACK;
                else
                begin
                    v = (it.op == OP_RET32) ? vstack[sp-1] : '0;
                    if (fc == 0)
                    begin
                        if (it.op == OP_RET32)
                        begin
                            sp--;
                            vstack[0] = v;
                            r.top_value = v;
                            has_top = 1;
                        end
                        r.finished = 1'b1;
                    end
                    else
                    begin
                        f = fc - 1;
                        if (it.op == OP_RET32 && frame_pos[f] >= VDEPTH)
                            r.error = ERR_STACK;
                        else
                        begin
                            fc = f;
                            sp = frame_pos[f];
                            fb = frame_fb[f];
                            r.resume_valid = 1'b1;
                            r.resume_address = frame_ret[f];
                            if (it.op == OP_RET32)
                            begin
                                vstack[sp] = v;
                                sp++;
                            end
                        end
                    end
                end
            end
            OP_PUSH, OP_PUSHADDR:
            begin
                if (sp >= VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    vstack[sp] = (it.op == OP_PUSH) ? it.immediate : 32'(it.byte_address);
                    sp++;
                end
            end
            OP_CALL:
            begin
                if (fc >= FDEPTH)
                    r.error = ERR_FRAME;
                else if (sp < it.callee_arg_count || sp + it.callee_local_count > VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    frame_fb[fc]  = fb;
                    fb            = sp - it.callee_arg_count;
                    frame_pos[fc] = fb;
                    frame_ret[fc] = it.return_address;
                    sp += it.callee_local_count;
                    fc++;
                end
            end
            OP_PUSHLOCAL, OP_LPOSTINC, OP_LPREINC, OP_LPOSTDEC, OP_LPREDEC:
            begin
                if (slot >= VDEPTH || sp >= VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    v = vstack[slot];
                    if (it.op == OP_LPOSTINC || it.op == OP_LPREINC)
                        vstack[slot] = v + 1;
                    else if (it.op == OP_LPOSTDEC || it.op == OP_LPREDEC)
                        vstack[slot] = v - 1;
                    if (it.op == OP_LPREINC || it.op == OP_LPREDEC)
                        v = vstack[slot];
                    vstack[sp] = v;
                    sp++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE, OP_NE,
            OP_LAND, OP_LOR:
            begin
                if (sp < 2)
                    r.error = ERR_STACK;
                else
                begin
                    b = vstack[sp-1];
                    a = vstack[sp-2];
                    if (it.op == OP_DIV && b == 0)
                        r.error = ERR_DIV0;
                    else
                    begin
                        sp--;
                        case (it.op)
                            OP_ADD:  v = a + b;
                            OP_SUB:  v = a - b;
                            OP_MUL:  v = a * b;
                            OP_DIV:  v = quotient(a, b);
                            OP_LT:   v = 32'($signed(a) < $signed(b));
                            OP_GT:   v = 32'($signed(a) > $signed(b));
                            OP_EQ:   v = 32'(a == b);
                            OP_LE:   v = 32'($signed(a) <= $signed(b));
                            OP_GE:   v = 32'($signed(a) >= $signed(b));
                            OP_NE:   v = 32'(a != b);
                            OP_LAND: v = 32'(a != 0 && b != 0);
                            default: v = 32'(a != 0 || b != 0);
                        endcase
                        vstack[sp-1] = v;
                    end
                end
            end
            OP_SETLOCAL:
            begin
                if (sp == 0 || slot >= VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    sp--;
                    vstack[slot] = vstack[sp];
                end
            end
            OP_MEMSET8:
            begin
                if (sp == 0)
                    r.error = ERR_STACK;
                else
                begin
                    sp--;
                    bmem[it.byte_address] = vstack[sp][7:0];
                end
            end
            OP_MEMPUSH8, OP_MPOSTINC, OP_MPREINC, OP_MPOSTDEC, OP_MPREDEC:
            begin
                if (sp >= VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    m = bmem[it.byte_address];
                    if (it.op == OP_MPOSTINC || it.op == OP_MPREINC)
                        bmem[it.byte_address] = m + 8'd1;
                    else if (it.op == OP_MPOSTDEC || it.op == OP_MPREDEC)
                        bmem[it.byte_address] = m - 8'd1;
                    if (it.op == OP_MPREINC || it.op == OP_MPREDEC)
                        m = bmem[it.byte_address];
                    vstack[sp] = 32'(m);
                    sp++;
                end
            end
            OP_IF:
            begin
                if (sp == 0)
                    r.error = ERR_STACK;
                else
                begin
                    sp--;
                    r.branch_taken = (vstack[sp] == 0);
                end
            end
            OP_JUMP:
                r.branch_taken = 1'b1;
            OP_NOT:
            begin
                if (sp == 0)
                    r.error = ERR_STACK;
                else
                    vstack[sp-1] = 32'(vstack[sp-1] == 0);
            end
            OP_POP:
            begin
                if (sp == 0)
                    r.error = ERR_STACK;
                else
                    sp--;
            end
            OP_START:
            begin
                if (it.callee_arg_count + it.callee_local_count > VDEPTH)
                    r.error = ERR_STACK;
                else
                begin
                    sp = it.callee_arg_count + it.callee_local_count;
                    fb = 0;
                    fc = 0;
                end
            end
            default:
                r.error = ERR_OPCODE;
        endcase
        if (r.error != ERR_NONE)
        begin
            r.branch_taken   = 1'b0;
            r.resume_valid   = 1'b0;
            r.resume_address = '0;
            r.finished       = 1'b0;
            has_top          = 0;
        end
        if (!has_top)
            r.top_value = (sp > 0) ? vstack[sp-1] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic instr_t mk(logic [OP_W-1:0] op, logic [31:0] imm = '0,
                                  logic [7:0] lidx = '0, logic [11:0] baddr = '0,
                                  logic [7:0] argc = '0, logic [7:0] lcnt = '0,
                                  logic [23:0] raddr = '0);
        instr_t it;
        it.op = op;
        it.immediate = imm;
        it.local_index = lidx;
        it.byte_address = baddr;
        it.callee_arg_count = argc;
        it.callee_local_count = lcnt;
        it.return_address = raddr;
        return it;
    endfunction

    task automatic add(instr_t it, bit typed = 0, outcome_t fx = '{default: '0});
        row_t rw;
        rw.ins = it;
        rw.typed = typed;
        rw.fixed = fx;
        program_q.push_back(rw);
    endtask

    function automatic outcome_t oc(logic [31:0] top, logic br, logic fin, logic [2:0] err);
        outcome_t r;
        r = '{default: '0};
        r.top_value = top;
        r.branch_taken = br;
        r.finished = fin;
        r.error = err;
        return r;
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        it.immediate = $urandom();
        case ($urandom_range(0, 7))
            0: it.immediate = 32'h8000_0000;
            1: it.immediate = 32'h7fff_ffff;
            2: it.immediate = $urandom_range(0, 3) - 1;
            default: ;
        endcase
        it.local_index  = ($urandom_range(0, 9) < 8) ? LIDX_W'($urandom_range(0, 7))
                                                     : LIDX_W'($urandom_range(0, 255));
        it.byte_address = ($urandom_range(0, 1) != 0) ? BADDR_W'($urandom_range(0, 7))
                                                      : BADDR_W'($urandom_range(0, 4095));
        it.callee_arg_count   = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 3))
                                                           : CNT_W'($urandom_range(0, 255));
        it.callee_local_count = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 3))
                                                           : CNT_W'($urandom_range(0, 255));
        it.return_address = RADDR_W'($urandom_range(0, 24'hffffff));
        // Keep the stack populated: pushes are frequent, bad opcodes rare.
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.op = OP_PUSH;
        else if (pick < 28)
            it.op = OP_W'($urandom_range(34, 63));
        else
            it.op = OP_W'($urandom_range(0, 33));
        return it;
    endfunction

    task automatic build_program();
        // Reset state, error codes, the divide extremes, byte memory, locals, call and return.
        add(mk(OP_RET), 1, oc('0, 1'b0, 1'b1, ERR_NONE));
        add(mk(OP_POP), 1, oc('0, 1'b0, 1'b0, ERR_STACK));
        add(mk(OP_BAD), 1, oc('0, 1'b0, 1'b0, ERR_OPCODE));
        add(mk(OP_JUMP), 1, oc('0, 1'b1, 1'b0, ERR_NONE));
        add(mk(OP_PUSH, 32'h8000_0000), 1, oc(32'h8000_0000, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_PUSH, 32'hffff_ffff), 1, oc(32'hffff_ffff, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_DIV), 1, oc(32'h8000_0000, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_PUSH, 32'h0), 1, oc('0, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_DIV), 1, oc('0, 1'b0, 1'b0, ERR_DIV0));
        add(mk(OP_POP));
        add(mk(OP_PUSH, 32'h7fff_ffff));
        add(mk(OP_ADD));
        add(mk(OP_PUSHADDR, '0, '0, 12'hfff), 1, oc(32'hfff, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_MEMSET8, '0, '0, 12'hfff));
        add(mk(OP_MEMPUSH8, '0, '0, 12'hfff));
        add(mk(OP_MPOSTINC, '0, '0, 12'h000), 1, oc('0, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_MPREINC, '0, '0, 12'h000), 1, oc(32'd2, 1'b0, 1'b0, ERR_NONE));
        add(mk(OP_MPOSTDEC, '0, '0, 12'h000));
        add(mk(OP_MPREDEC, '0, '0, 12'h000));
        add(mk(OP_CALL, '0, '0, '0, 8'd1, 8'd0, 24'hffffff));
        add(mk(OP_PUSHLOCAL, '0, 8'd0));
        add(mk(OP_LPOSTINC, '0, 8'd0));
        add(mk(OP_LPREDEC, '0, 8'd0));
        add(mk(OP_SETLOCAL, '0, 8'd0));
        add(mk(OP_RET32));
    endtask

    task automatic build_fill();
        // Fill the whole value stack, then hit the full-stack corners.
        add(mk(OP_START));
        for (int i = 0; i < VDEPTH; i++)
            add(mk(OP_PUSH, $urandom()));
        add(mk(OP_PUSH, 32'h1234));
        add(mk(OP_PUSHADDR));
        add(mk(OP_PUSHLOCAL));
        add(mk(OP_LPOSTINC));
        add(mk(OP_MEMPUSH8));
        add(mk(OP_CALL, '0, '0, '0, 8'd0, 8'd1));
        add(mk(OP_CALL, '0, '0, '0, 8'd0, 8'd0, 24'h00abcd));
        add(mk(OP_PUSHLOCAL, '0, 8'd0));
        add(mk(OP_RET32));
        add(mk(OP_RET));
        repeat (8) add(mk(OP_POP));
        add(mk(OP_CALL, '0, '0, '0, 8'd0, 8'd0, 24'h123456));
        add(mk(OP_SETLOCAL, '0, 8'd255));
        add(mk(OP_RET));
    endtask

    task automatic build_random();
        add(mk(OP_START, '0, '0, '0, 8'd255, 8'd255));
        for (int i = 0; i < 400; i++)
        begin
            if (i == 200)
            begin
                // Nest past the frame depth, then unwind to the outermost frame.
                for (int k = 0; k <= FDEPTH; k++)
                    add(mk(OP_CALL, '0, '0, '0, 8'd0, 8'd0,
                           RADDR_W'($urandom_range(0, 24'hffffff))));
                for (int k = 0; k <= FDEPTH + 4; k++)
                    add(mk(OP_RET));
            end
            add(random_instr());
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch at result %0d: %s got %0h, want %0h", n_results, field, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            outcome_t p;
            // Run the predictor for every request so the state stays in step;
            // table rows with a typed outcome take precedence.
            p = execute(program_q[n_accepted].ins);
            pending_q.push_back(program_q[n_accepted].typed ? program_q[n_accepted].fixed : p);
            n_accepted++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            outcome_t w;
            if (pending_q.size() == 0)
            begin
                n_errors++;
                $display("result %0d arrived with no request outstanding", n_results);
            end
            else
            begin
                w = pending_q.pop_front();
                if (w.error != ERR_NONE)
                    n_fail_err++;
                if (out_ch.top_value !== w.top_value)
                    report("top_value", out_ch.top_value, w.top_value);
                if (out_ch.branch_taken !== w.branch_taken)
                    report("branch_taken", 32'(out_ch.branch_taken), 32'(w.branch_taken));
                if (out_ch.resume_valid !== w.resume_valid)
                    report("resume_valid", 32'(out_ch.resume_valid), 32'(w.resume_valid));
                if (out_ch.resume_address !== w.resume_address)
                    report("resume_address", 32'(out_ch.resume_address),
                           32'(w.resume_address));
                if (out_ch.finished !== w.finished)
                    report("finished", 32'(out_ch.finished), 32'(w.finished));
                if (out_ch.error !== w.error)
                    report("error", 32'(out_ch.error), 32'(w.error));
            end
            n_results++;
        end
    end

    // Watchdog: count cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("[stack_bytecode_execute_unit_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random ready gaps, burst stretches, one long hold-off.
    // ------------------------------------------------------------------------
    initial
    begin
        int  gap;
        bit  held;
        held = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = ((n_results / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (!held && n_results >= 2200)
            begin
                held = 1;
                gap  = LONG_HOLD;
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Request side and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int gap, n_directed;
        sp = 0;
        fb = 0;
        fc = 0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;
        n_fail_err = 0;
        idle_cycles = 0;
        stim_done = 0;
        foreach (vstack[i]) vstack[i] = '0;
        foreach (bmem[i]) bmem[i] = '0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.immediate = '0;
        in_ch.local_index = '0;
        in_ch.byte_address = '0;
        in_ch.callee_arg_count = '0;
        in_ch.callee_local_count = '0;
        in_ch.return_address = '0;
        rst_n = 1'b0;

        build_program();
        n_directed = program_q.size();
        build_fill();
        build_random();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (program_q[k])
        begin
            // Hold off after the directed table until everything has drained.
            if (k == n_directed)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            gap = ((k / 60) % 3 == 2) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_ch.valid              <= 1'b1;
            in_ch.op                 <= program_q[k].ins.op;
            in_ch.immediate          <= program_q[k].ins.immediate;
            in_ch.local_index        <= program_q[k].ins.local_index;
            in_ch.byte_address       <= program_q[k].ins.byte_address;
            in_ch.callee_arg_count   <= program_q[k].ins.callee_arg_count;
            in_ch.callee_local_count <= program_q[k].ins.callee_local_count;
            in_ch.return_address     <= program_q[k].ins.return_address;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;

        // Drain outstanding results, then allow stray late results to show up.
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests: directed table, full-stack corners, frame overflow,",
                 n_accepted);
        $display("and random mix; %0d results checked, %0d with error codes",
                 n_results, n_fail_err);
        if (n_errors == 0)
            $display("[stack_bytecode_execute_unit_core] OK");
        else
            $display("[stack_bytecode_execute_unit_core] ERROR");
        $finish;
    end

endmodule
